FILE: rtl/gtvn_pkg.sv
// Shared types and constants of the grid terrain vertex normal block.
`timescale 1ns / 1ps

package gtvn_pkg;

   // Fixed-point one in Q1.14.
   localparam int UNIT_Q14 = 16384;

   // Command codes carried in the cmd field of a request word.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_GRID_ROWS    = 2'd0;
   localparam logic [1:0] CSR_GRID_COLS    = 2'd1;
   localparam logic [1:0] CSR_CELL_SPACING = 2'd2;

   // Sequencer step limits.
   localparam logic [3:0] DIV_LAST  = 4'd13;  // 14 quotient bits of the row/column split
   localparam logic [3:0] READ_LAST = 4'd8;   // 3 x 3 neighborhood of heights
   localparam logic [2:0] FACE_LAST = 3'd5;   // six candidate triangles

   typedef struct packed {
      logic               cmd;
      logic [13:0]        vertex_index;
      logic signed [15:0] height_value;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic [2:0]         face_count;
      logic               index_error;
   } rsp_word_type;

   // Vector entering the normalize unit.
   typedef struct packed {
      logic signed [17:0] x;
      logic signed [17:0] y;
      logic signed [17:0] z;
   } vec_type;

   // Unit vector leaving the normalize unit, Q1.14.
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } unit_vec_type;

   typedef enum logic [1:0] {
      RSP_ERROR,
      RSP_FLAT,
      RSP_UP,
      RSP_NORMAL
   } rsp_mode_type;

   typedef enum logic [2:0] {
      C_IDLE,
      C_DIVIDE,
      C_READ,
      C_FACE,
      C_FACE_WAIT,
      C_FINAL,
      C_FINAL_WAIT,
      C_RESPOND
   } ctrl_state_type;

   typedef enum logic [2:0] {
      N_IDLE,
      N_SHIFT,
      N_SQUARE,
      N_ROOT,
      N_DIV_LOAD,
      N_DIVIDE,
      N_DONE
   } norm_state_type;

   typedef struct packed {
      logic         accept;
      logic         div_step;
      logic         rd_en;
      logic [3:0]   rd_sel;
      logic [2:0]   face_sel;
      logic         norm_start;
      logic         norm_final;
      logic         acc_add;
      logic         rsp_fire;
      rsp_mode_type rsp_mode;
   } ctrl_cmd_type;

   typedef struct packed {
      logic       req_query;
      logic       req_in_range;
      logic [5:0] face_en;
      logic       acc_zero;
      logic       norm_done;
   } dp_status_type;

endpackage

FILE: rtl/grid_terrain_vertex_normal_top.sv
// Top level of the grid terrain vertex normal block.
`timescale 1ns / 1ps

// The block holds a height map of up to MAX_ROWS by MAX_COLS vertices and
// answers vertex normal queries. A word is taken when start is high and busy
// is low. A height write gives no result; busy never rises for it, so writes
// may stream one per cycle while no query is in progress. A query outside the
// grid returns an error word through the respond state and the result
// register. A query inside the grid splits the index into row and column,
// reads the 3 x 3 neighborhood of heights, then runs each touching triangle
// and, if their sum is not zero, the final sum through one shared normalize
// unit. That unit works one square root bit and one quotient bit per cycle;
// a pass runs longer the further the vector must be scaled up. The result
// word is shown on rsp_word with rsp_strobe high for exactly one cycle and
// cannot be held off by the receiver. Heights must be written before they
// are queried; the height memory is not cleared by reset. The user must
// change settings only while the block is idle; the block does not enforce it.
module grid_terrain_vertex_normal_top #(
   parameter int MAX_ROWS = 128,
   parameter int MAX_COLS = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  gtvn_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output gtvn_pkg::rsp_word_type rsp_word,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_wdata
);

   gtvn_pkg::ctrl_cmd_type  ctrl_cmd;
   gtvn_pkg::dp_status_type dp_status;

   // The sequencer steps a query through its phases and drives the datapath.
   gtvn_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (dp_status),
      .cmd    (ctrl_cmd)
   );

   // The datapath holds settings, heights, the normalize unit and the result word.
   gtvn_dpath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_word   (req_word),
      .cmd        (ctrl_cmd),
      .status     (dp_status),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

`ifndef SYNTHESIS
   // A result word follows only work the sequencer was busy with.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result word without a pending query");

   // One query gives one result word, never two in a row.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // The normalize unit is only started while a query is in progress.
   a_norm_in_query: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.norm_start |-> busy)
      else $error("normalize started while idle");

   // An error word reports no faces.
   a_err_no_faces: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.index_error) |-> (rsp_word.face_count == 3'd0))
      else $error("error word with nonzero face count");
`endif

endmodule

FILE: rtl/gtvn_ctrl.sv
// Query sequencer of the grid terrain vertex normal block.
`timescale 1ns / 1ps

module gtvn_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  gtvn_pkg::dp_status_type status,
   output gtvn_pkg::ctrl_cmd_type  cmd
);

   gtvn_pkg::ctrl_state_type state_ff, state_in;
   gtvn_pkg::rsp_mode_type   mode_ff, mode_in;
   logic [3:0]               step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gtvn_pkg::C_IDLE;
         mode_ff  <= gtvn_pkg::RSP_ERROR;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      step_in      = step_ff;
      busy         = 1'b1;
      cmd          = '0;
      cmd.rd_sel   = step_ff;
      cmd.face_sel = step_ff[2:0];
      cmd.rsp_mode = mode_ff;
      unique case (state_ff)
         gtvn_pkg::C_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.accept = 1'b1;
               if (status.req_query) begin
                  step_in = '0;
                  if (status.req_in_range) begin
                     state_in = gtvn_pkg::C_DIVIDE;
                  end else begin
                     mode_in  = gtvn_pkg::RSP_ERROR;
                     state_in = gtvn_pkg::C_RESPOND;
                  end
               end
            end
         end
         gtvn_pkg::C_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 4'd1;
            if (step_ff == gtvn_pkg::DIV_LAST) begin
               step_in  = '0;
               state_in = gtvn_pkg::C_READ;
            end
         end
         gtvn_pkg::C_READ: begin
            cmd.rd_en = 1'b1;
            step_in   = step_ff + 4'd1;
            if (step_ff == gtvn_pkg::READ_LAST) begin
               step_in  = '0;
               state_in = gtvn_pkg::C_FACE;
            end
         end
         gtvn_pkg::C_FACE: begin
            priority if (status.face_en[step_ff[2:0]]) begin
               cmd.norm_start = 1'b1;
               state_in       = gtvn_pkg::C_FACE_WAIT;
            end else if (step_ff[2:0] == gtvn_pkg::FACE_LAST) begin
               state_in = gtvn_pkg::C_FINAL;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         gtvn_pkg::C_FACE_WAIT: begin
            if (status.norm_done) begin
               cmd.acc_add = 1'b1;
               if (step_ff[2:0] == gtvn_pkg::FACE_LAST) begin
                  state_in = gtvn_pkg::C_FINAL;
               end else begin
                  step_in  = step_ff + 4'd1;
                  state_in = gtvn_pkg::C_FACE;
               end
            end
         end
         gtvn_pkg::C_FINAL: begin
            priority if (status.face_en == '0) begin
               mode_in  = gtvn_pkg::RSP_FLAT;
               state_in = gtvn_pkg::C_RESPOND;
            end else if (status.acc_zero) begin
               mode_in  = gtvn_pkg::RSP_UP;
               state_in = gtvn_pkg::C_RESPOND;
            end else begin
               cmd.norm_start = 1'b1;
               cmd.norm_final = 1'b1;
               state_in       = gtvn_pkg::C_FINAL_WAIT;
            end
         end
         gtvn_pkg::C_FINAL_WAIT: begin
            if (status.norm_done) begin
               mode_in  = gtvn_pkg::RSP_NORMAL;
               state_in = gtvn_pkg::C_RESPOND;
            end
         end
         gtvn_pkg::C_RESPOND: begin
            cmd.rsp_fire = 1'b1;
            state_in     = gtvn_pkg::C_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/gtvn_norm.sv
// Iterative vector normalize unit: scale, sum of squares, square root, divide.
`timescale 1ns / 1ps

module gtvn_norm (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  gtvn_pkg::vec_type      vec,
   output logic                   done,
   output gtvn_pkg::unit_vec_type unit
);

   localparam logic [4:0] SQ_LAST   = 5'd2;
   localparam logic [4:0] ROOT_LAST = 5'd31;
   localparam logic [4:0] QBIT_LAST = 5'd15;
   localparam logic [1:0] COMP_LAST = 2'd2;

   gtvn_pkg::norm_state_type state_ff, state_in;

   logic [16:0] mag_ff [3];
   logic [2:0]  neg_ff;
   logic [35:0] sum_ff;
   logic [63:0] v_ff;
   logic [63:0] res_ff;
   logic [63:0] bit_ff;
   logic [45:0] rem_ff;
   logic [46:0] dsh_ff;
   logic [15:0] q_ff;
   logic [15:0] nrm_ff [3];
   logic [4:0]  cnt_ff;
   logic [1:0]  comp_ff;

   logic signed [17:0] in_c [3];
   logic        in_zero;
   logic        top_set;
   logic [16:0] sq_mag;
   logic [33:0] sq;
   logic [35:0] sq_sum;
   logic [63:0] root_try;
   logic        root_ge;
   logic [31:0] len;
   logic        div_ge;
   logic [15:0] q_next;
   logic [15:0] q_cap;

   always_comb begin
      in_c[0]  = vec.x;
      in_c[1]  = vec.y;
      in_c[2]  = vec.z;
      in_zero  = (vec.x == '0) && (vec.y == '0) && (vec.z == '0);
      top_set  = mag_ff[0][16] | mag_ff[1][16] | mag_ff[2][16];
      sq_mag   = mag_ff[cnt_ff[1:0]];
      sq       = sq_mag * sq_mag;
      sq_sum   = sum_ff + 36'(sq);
      root_try = res_ff + bit_ff;
      root_ge  = v_ff >= root_try;
      len      = res_ff[31:0];
      div_ge   = {1'b0, rem_ff} >= dsh_ff;
      q_next   = {q_ff[14:0], div_ge};
      q_cap    = (q_next > 16'(gtvn_pkg::UNIT_Q14)) ? 16'(gtvn_pkg::UNIT_Q14) : q_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gtvn_pkg::N_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         gtvn_pkg::N_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_ff[i] <= in_c[i][17];
                  mag_ff[i] <= in_c[i][17] ? 17'(-in_c[i]) : 17'(in_c[i]);
                  nrm_ff[i] <= '0;
               end
            end
         end
         gtvn_pkg::N_SHIFT: begin
            if (!top_set) begin
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= {mag_ff[i][15:0], 1'b0};
               end
            end else begin
               sum_ff <= '0;
               cnt_ff <= '0;
            end
         end
         gtvn_pkg::N_SQUARE: begin
            sum_ff <= sq_sum;
            v_ff   <= {sq_sum, 28'd0};
            res_ff <= '0;
            bit_ff <= 64'd1 << 62;
            cnt_ff <= (cnt_ff == SQ_LAST) ? 5'd0 : cnt_ff + 5'd1;
         end
         gtvn_pkg::N_ROOT: begin
            if (root_ge) begin
               v_ff   <= v_ff - root_try;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff  <= bit_ff >> 2;
            cnt_ff  <= cnt_ff + 5'd1;
            comp_ff <= '0;
         end
         gtvn_pkg::N_DIV_LOAD: begin
            // Rounded quotient: add half the divisor before dividing.
            rem_ff <= 46'({mag_ff[comp_ff], 28'd0}) + 46'(len[31:1]);
            dsh_ff <= {len, 15'd0};
            q_ff   <= '0;
            cnt_ff <= '0;
         end
         gtvn_pkg::N_DIVIDE: begin
            if (div_ge) begin
               rem_ff <= rem_ff - dsh_ff[45:0];
            end
            dsh_ff <= dsh_ff >> 1;
            q_ff   <= q_next;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == QBIT_LAST) begin
               nrm_ff[comp_ff] <= neg_ff[comp_ff] ? -q_cap : q_cap;
               comp_ff         <= comp_ff + 2'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      done     = 1'b0;
      unique case (state_ff)
         gtvn_pkg::N_IDLE: begin
            if (start) begin
               state_in = in_zero ? gtvn_pkg::N_DONE : gtvn_pkg::N_SHIFT;
            end
         end
         gtvn_pkg::N_SHIFT: begin
            if (top_set) begin
               state_in = gtvn_pkg::N_SQUARE;
            end
         end
         gtvn_pkg::N_SQUARE: begin
            if (cnt_ff == SQ_LAST) begin
               state_in = gtvn_pkg::N_ROOT;
            end
         end
         gtvn_pkg::N_ROOT: begin
            if (cnt_ff == ROOT_LAST) begin
               state_in = gtvn_pkg::N_DIV_LOAD;
            end
         end
         gtvn_pkg::N_DIV_LOAD: begin
            state_in = gtvn_pkg::N_DIVIDE;
         end
         gtvn_pkg::N_DIVIDE: begin
            if (cnt_ff == QBIT_LAST) begin
               state_in = (comp_ff == COMP_LAST) ? gtvn_pkg::N_DONE : gtvn_pkg::N_DIV_LOAD;
            end
         end
         gtvn_pkg::N_DONE: begin
            done     = 1'b1;
            state_in = gtvn_pkg::N_IDLE;
         end
         default: begin
            state_in = gtvn_pkg::N_IDLE;
         end
      endcase
   end

   assign unit.x = nrm_ff[0];
   assign unit.y = nrm_ff[1];
   assign unit.z = nrm_ff[2];

endmodule

FILE: rtl/gtvn_dpath.sv
// Datapath: settings, height memory, row/column split, face vectors, sum, result word.
`timescale 1ns / 1ps

module gtvn_dpath #(
   parameter int MAX_ROWS = 128,
   parameter int MAX_COLS = 128
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [15:0]             csr_wdata,
   input  gtvn_pkg::req_word_type  req_word,
   input  gtvn_pkg::ctrl_cmd_type  cmd,
   output gtvn_pkg::dp_status_type status,
   output logic                    rsp_strobe,
   output gtvn_pkg::rsp_word_type  rsp_word
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = ((AW > 14) ? AW : 14) + 2;

   logic [7:0]  rows_ff, cols_ff;
   logic [15:0] spacing_ff;
   logic [15:0] total;

   logic [13:0] idx_ff;
   logic [13:0] dvd_ff;
   logic [7:0]  rem_ff;
   logic [8:0]  rem_try;
   logic        div_ge;

   logic signed [15:0] mem [DEPTH];
   logic signed [15:0] mem_q_ff;
   logic [3:0]         rd_sel_ff;
   logic               rd_vld_ff;
   logic signed [15:0] h_ff [9];
   logic [CW-1:0]      addr_calc;
   logic [AW-1:0]      rd_addr;

   logic has_up, has_left, has_right, has_down;
   logic signed [16:0] face_a, face_b;

   gtvn_pkg::vec_type      norm_vec;
   gtvn_pkg::unit_vec_type norm_out;
   logic                   norm_done;

   logic signed [17:0] acc_x_ff, acc_y_ff, acc_z_ff;

   logic                   strobe_ff;
   gtvn_pkg::rsp_word_type rsp_ff, rsp_in;

   function automatic logic signed [16:0] diff(input logic signed [15:0] p,
                                               input logic signed [15:0] q);
      return {p[15], p} - {q[15], q};
   endfunction

   // Settings; row and column counts above the grid size act as the grid size.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff    <= 8'd2;
         cols_ff    <= 8'd2;
         spacing_ff <= 16'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            gtvn_pkg::CSR_GRID_ROWS: begin
               rows_ff <= (csr_wdata[7:0] > MAX_ROWS) ? 8'(MAX_ROWS) : csr_wdata[7:0];
            end
            gtvn_pkg::CSR_GRID_COLS: begin
               cols_ff <= (csr_wdata[7:0] > MAX_COLS) ? 8'(MAX_COLS) : csr_wdata[7:0];
            end
            gtvn_pkg::CSR_CELL_SPACING: begin
               spacing_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign total               = 16'(rows_ff) * 16'(cols_ff);
   assign status.req_query    = (req_word.cmd == gtvn_pkg::CMD_QUERY);
   assign status.req_in_range = {2'b00, req_word.vertex_index} < total;

   // Row = index / columns, column = remainder, one quotient bit per step.
   assign rem_try = {rem_ff, dvd_ff[13]};
   assign div_ge  = rem_try >= {1'b0, cols_ff};

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         idx_ff <= req_word.vertex_index;
         dvd_ff <= req_word.vertex_index;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[12:0], div_ge};
         rem_ff <= div_ge ? 8'(rem_try - {1'b0, cols_ff}) : rem_try[7:0];
      end
   end

   assign has_up    = (dvd_ff != '0);
   assign has_left  = (rem_ff != '0);
   assign has_right = ({1'b0, rem_ff} + 9'd1) < {1'b0, cols_ff};
   assign has_down  = ({1'b0, dvd_ff} + 15'd1) < 15'(rows_ff);

   assign status.face_en = {has_down & has_right, has_down & has_left, has_down & has_left,
                            has_up & has_right, has_up & has_right, has_up & has_left};

   // Neighborhood address: taps run row-major over rows r-1..r+1, columns c-1..c+1.
   always_comb begin
      unique case (cmd.rd_sel)
         4'd0:    addr_calc = CW'(idx_ff) - CW'(cols_ff) - CW'(1);
         4'd1:    addr_calc = CW'(idx_ff) - CW'(cols_ff);
         4'd2:    addr_calc = CW'(idx_ff) - CW'(cols_ff) + CW'(1);
         4'd3:    addr_calc = CW'(idx_ff) - CW'(1);
         4'd4:    addr_calc = CW'(idx_ff);
         4'd5:    addr_calc = CW'(idx_ff) + CW'(1);
         4'd6:    addr_calc = CW'(idx_ff) + CW'(cols_ff) - CW'(1);
         4'd7:    addr_calc = CW'(idx_ff) + CW'(cols_ff);
         4'd8:    addr_calc = CW'(idx_ff) + CW'(cols_ff) + CW'(1);
         default: addr_calc = CW'(idx_ff);
      endcase
      rd_addr = AW'(addr_calc);
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && (req_word.cmd == gtvn_pkg::CMD_WRITE) && status.req_in_range) begin
         mem[AW'(req_word.vertex_index)] <= req_word.height_value;
      end
      if (cmd.rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      rd_sel_ff <= cmd.rd_sel;
      if (rd_vld_ff) begin
         h_ff[rd_sel_ff] <= mem_q_ff;
      end
   end

   // Face vector (x and z; y is the spacing) for each of the six triangles.
   always_comb begin
      unique case (cmd.face_sel)
         3'd0:    begin face_a = diff(h_ff[3], h_ff[4]); face_b = diff(h_ff[4], h_ff[1]); end
         3'd1:    begin face_a = diff(h_ff[1], h_ff[2]); face_b = diff(h_ff[4], h_ff[1]); end
         3'd2:    begin face_a = diff(h_ff[4], h_ff[5]); face_b = diff(h_ff[5], h_ff[2]); end
         3'd3:    begin face_a = diff(h_ff[3], h_ff[4]); face_b = diff(h_ff[6], h_ff[3]); end
         3'd4:    begin face_a = diff(h_ff[6], h_ff[7]); face_b = diff(h_ff[7], h_ff[4]); end
         3'd5:    begin face_a = diff(h_ff[4], h_ff[5]); face_b = diff(h_ff[7], h_ff[4]); end
         default: begin face_a = '0; face_b = '0; end
      endcase
      if (cmd.norm_final) begin
         norm_vec.x = acc_x_ff;
         norm_vec.y = acc_y_ff;
         norm_vec.z = acc_z_ff;
      end else begin
         norm_vec.x = {face_a[16], face_a};
         norm_vec.y = {2'b00, spacing_ff};
         norm_vec.z = {face_b[16], face_b};
      end
   end

   gtvn_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (cmd.norm_start),
      .vec   (norm_vec),
      .done  (norm_done),
      .unit  (norm_out)
   );

   assign status.norm_done = norm_done;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         acc_z_ff <= '0;
      end else if (cmd.acc_add) begin
         acc_x_ff <= acc_x_ff + {{2{norm_out.x[15]}}, norm_out.x};
         acc_y_ff <= acc_y_ff + {{2{norm_out.y[15]}}, norm_out.y};
         acc_z_ff <= acc_z_ff + {{2{norm_out.z[15]}}, norm_out.z};
      end
   end

   assign status.acc_zero = (acc_x_ff == '0) && (acc_y_ff == '0) && (acc_z_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.rsp_fire;
      end
   end

   always_comb begin
      rsp_in            = '0;
      rsp_in.face_count = 3'($countones(status.face_en));
      unique case (cmd.rsp_mode)
         gtvn_pkg::RSP_ERROR: begin
            rsp_in.face_count  = '0;
            rsp_in.index_error = 1'b1;
         end
         gtvn_pkg::RSP_FLAT: begin
         end
         gtvn_pkg::RSP_UP: begin
            rsp_in.normal_y = 16'(gtvn_pkg::UNIT_Q14);
         end
         gtvn_pkg::RSP_NORMAL: begin
            rsp_in.normal_x = norm_out.x;
            rsp_in.normal_y = norm_out.y;
            rsp_in.normal_z = norm_out.z;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule
